// ===== rtl/core/sgsm_pkg.sv =====
// Shared types and constants for the send gain slew mixer.
package sgsm_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int GAIN_W      = 16;
  localparam int SLEW_W      = 12;
  localparam int CHCNT_W     = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RPROD_W     = GAIN_W + SLEW_W;      // |diff| * ramp_frame
  localparam int PROD_W      = SAMPLE_W + GAIN_W;    // sample * gain
  localparam int SUM_W       = PROD_W - 12 + 1;      // accum + scaled
  localparam int CNT_W       = 5;

  localparam int DEF_MAX_CHANNELS = 8;

  localparam logic [GAIN_W-1:0]  OLD_GAIN_RST = 16'd4096;
  localparam logic [GAIN_W-1:0]  NEW_GAIN_RST = 16'd4096;
  localparam logic [SLEW_W-1:0]  SLEW_RST     = 12'd0;
  localparam logic [CHCNT_W-1:0] CHCNT_RST    = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OLD_GAIN    = 3'd0,
    REG_NEW_GAIN    = 3'd1,
    REG_SLEW_FRAMES = 3'd2,
    REG_CHAN_COUNT  = 3'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMUL,
    ST_DIV,
    ST_GAIN,
    ST_SMUL,
    ST_FIN
  } state_t;

endpackage

// ===== rtl/core/send_gain_slew_mixer_top.sv =====
// Send gain slew mixer: ramped gain, bit-serial multiply/divide, saturating accumulate.
//
// Each item takes sample_in, multiplies it by the send gain (unsigned Q4.12),
// rounds half up to Q1.23, adds accum_in and saturates to 24 bits. While a
// ramp is in progress the gain is old_gain + trunc((new_gain - old_gain) *
// ramp_frame / slew_frames), built by a one-bit-per-cycle shift-add multiply
// over the frame bits, a restoring divide and a gain update. The sample
// multiply then takes one gain bit per cycle, and the round/add/clamp is done
// in a final state that waits while the output register still holds an
// unaccepted result. A new item is taken only once the block is back in idle.
// A finished result sits in an output register so a new item can be
// accepted while it waits. Writing old_gain or new_gain restarts the ramp;
// the user must see that configuration is written only while no item is in
// flight, as the block itself does not enforce it.
module send_gain_slew_mixer_top #(
  parameter int MAX_CHANNELS = sgsm_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [sgsm_pkg::SAMPLE_W-1:0]    in_sample_in,
  input  logic signed [sgsm_pkg::SAMPLE_W-1:0]    in_accum_in,
  input  logic                                    in_block_last,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [sgsm_pkg::SAMPLE_W-1:0]    out_accum_out,
  output logic                                    out_ramping,
  output logic                                    out_out_last,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [sgsm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [sgsm_pkg::CFG_DATA_W-1:0]         cfg_data
);
  import sgsm_pkg::*;

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [CHCNT_W-1:0] MAX_CH = CHCNT_W'(MAX_CHANNELS);
  localparam logic [CNT_W-1:0] RMUL_LAST = CNT_W'(SLEW_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(RPROD_W - 1);
  localparam logic [CNT_W-1:0] SMUL_LAST = CNT_W'(GAIN_W - 1);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(8388608);

  // configuration
  logic [GAIN_W-1:0]  old_gain_r;
  logic [GAIN_W-1:0]  new_gain_r;
  logic [SLEW_W-1:0]  slew_r;
  logic [CHCNT_W-1:0] chcnt_r;

  // frame state
  logic [SLEW_W-1:0]  ramp_frame_r;
  logic [CH_W-1:0]    chan_idx_r;

  // control
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;

  // datapath
  logic [RPROD_W-1:0]         mac_r;
  logic [SLEW_W-1:0]          fr_r;
  logic [SLEW_W-1:0]          rem_r;
  logic [GAIN_W-1:0]          quo_r;
  logic                       neg_r;
  logic [GAIN_W-1:0]          gain_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] accum_r;
  logic                       last_r;
  logic                       ramp_r;

  // output register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] accum_out_r;
  logic                       ramping_r;
  logic                       out_last_r;

  logic                       in_take;
  logic                       out_load;
  logic                       cnt_done;
  logic                       ramp_now;
  logic [CHCNT_W-1:0]         chans_eff;
  logic                       frame_end;
  logic [SLEW_W:0]            trial;
  logic                       trial_ge;
  logic [SLEW_W:0]            trial_sub;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] sum_sat;

  assign cfg_ready     = rst_n;
  assign in_stall      = !rst_n || (state_r != ST_IDLE);
  assign in_take       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_accum_out = accum_out_r;
  assign out_ramping   = ramping_r;
  assign out_out_last  = out_last_r;

  assign ramp_now = (slew_r != '0) && (ramp_frame_r < slew_r);

  always_comb begin
    if (chcnt_r == '0) begin
      chans_eff = CHCNT_W'(1);
    end else if (chcnt_r > MAX_CH) begin
      chans_eff = MAX_CH;
    end else begin
      chans_eff = chcnt_r;
    end
  end

  assign frame_end = (CHCNT_W'(chan_idx_r) + CHCNT_W'(1)) >= chans_eff;

  // restoring divide step
  assign trial     = {rem_r, mac_r[RPROD_W-1]};
  assign trial_ge  = trial >= {1'b0, slew_r};
  assign trial_sub = trial - {1'b0, slew_r};

  // round half up, floor shift, add, clamp
  assign rnd = prod_r + PROD_W'(2048);
  assign sum = SUM_W'(accum_r) + SUM_W'($signed(rnd[PROD_W-1:12]));
  always_comb begin
    if (sum > SUM_MAX) begin
      sum_sat = SUM_MAX[SAMPLE_W-1:0];
    end else if (sum < SUM_MIN) begin
      sum_sat = SUM_MIN[SAMPLE_W-1:0];
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_done  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ramp_now ? ST_RMUL : ST_SMUL;
        end
      end
      ST_RMUL: begin
        if (cnt_r == RMUL_LAST) begin
          cnt_done  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          cnt_done  = 1'b1;
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        if (cnt_r == SMUL_LAST) begin
          cnt_done  = 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_take || cnt_done) begin
        cnt_r <= '0;
      end else if (state_r == ST_RMUL || state_r == ST_DIV || state_r == ST_SMUL) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  // configuration and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_gain_r   <= OLD_GAIN_RST;
      new_gain_r   <= NEW_GAIN_RST;
      slew_r       <= SLEW_RST;
      chcnt_r      <= CHCNT_RST;
      ramp_frame_r <= '0;
      chan_idx_r   <= '0;
    end else begin
      if (in_take) begin
        if (frame_end) begin
          chan_idx_r <= '0;
          if (ramp_now) begin
            ramp_frame_r <= ramp_frame_r + SLEW_W'(1);
          end
        end else begin
          chan_idx_r <= chan_idx_r + CH_W'(1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OLD_GAIN: begin
            old_gain_r   <= cfg_data[GAIN_W-1:0];
            ramp_frame_r <= '0;
          end
          REG_NEW_GAIN: begin
            new_gain_r   <= cfg_data[GAIN_W-1:0];
            ramp_frame_r <= '0;
          end
          REG_SLEW_FRAMES: slew_r  <= cfg_data[SLEW_W-1:0];
          REG_CHAN_COUNT:  chcnt_r <= cfg_data[CHCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // serial datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          sample_r <= in_sample_in;
          accum_r  <= in_accum_in;
          last_r   <= in_block_last;
          ramp_r   <= ramp_now;
          mac_r    <= '0;
          rem_r    <= '0;
          quo_r    <= '0;
          prod_r   <= '0;
          fr_r     <= ramp_frame_r;
          neg_r    <= new_gain_r < old_gain_r;
          if (!ramp_now) begin
            gain_r <= new_gain_r;
          end else if (new_gain_r < old_gain_r) begin
            gain_r <= old_gain_r - new_gain_r;
          end else begin
            gain_r <= new_gain_r - old_gain_r;
          end
        end
      end
      ST_RMUL: begin
        // |diff| * ramp_frame, frame bits MSB first
        mac_r <= {mac_r[RPROD_W-2:0], 1'b0} + (fr_r[SLEW_W-1] ? RPROD_W'(gain_r) : '0);
        fr_r  <= {fr_r[SLEW_W-2:0], 1'b0};
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[SLEW_W-1:0] : trial[SLEW_W-1:0];
        quo_r <= {quo_r[GAIN_W-2:0], trial_ge};
        mac_r <= {mac_r[RPROD_W-2:0], 1'b0};
      end
      ST_GAIN: begin
        gain_r <= neg_r ? (old_gain_r - quo_r) : (old_gain_r + quo_r);
      end
      ST_SMUL: begin
        prod_r <= {prod_r[PROD_W-2:0], 1'b0}
                  + (gain_r[GAIN_W-1] ? PROD_W'(sample_r) : '0);
        gain_r <= {gain_r[GAIN_W-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accum_out_r <= sum_sat;
      ramping_r   <= ramp_r;
      out_last_r  <= last_r;
    end
  end

endmodule

// ===== bench/sgsm_mix_checker.sv =====
`timescale 1ns / 100ps
// Checker for the send gain slew mixer: watches the channels, predicts each result, compares.
module sgsm_mix_checker #(
  parameter int MAX_CHANNELS = sgsm_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [sgsm_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic signed [sgsm_pkg::SAMPLE_W-1:0] in_accum_in,
  input  logic                                 in_block_last,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [sgsm_pkg::SAMPLE_W-1:0] out_accum_out,
  input  logic                                 out_ramping,
  input  logic                                 out_out_last,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [sgsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgsm_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   fail_count,
  output int                                   mixes_pending,
  output int                                   mixes_checked,
  output int                                   ramp_mixes
);
  import sgsm_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accum;
    logic                       ramping;
    logic                       last;
  } mix_t;

  localparam longint SAT_HI     = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint SAT_LO     = -(longint'(1) << (SAMPLE_W - 1));
  localparam longint ROUND_BIAS = 2048;
  localparam int     FRAC_DROP  = 12;
  localparam int     MAX_PRINTED = 30;

  logic [GAIN_W-1:0]  old_gain_q;
  logic [GAIN_W-1:0]  new_gain_q;
  logic [SLEW_W-1:0]  slew_q;
  logic [CHCNT_W-1:0] chans_q;
  logic [SLEW_W-1:0]  ramp_frame_q;
  int                 chan_pos;

  mix_t pending_mixes[$];
  int   n_fail = 0;
  int   n_checked = 0;
  int   n_ramp = 0;

  task automatic report_mismatch(input string what);
    n_fail++;
    if (n_fail <= MAX_PRINTED)
      $display("%0t ns mismatch: %s", $time, what);
  endtask

  // Works out one result and advances the channel/frame counters.
  function automatic mix_t mix_sample(input logic signed [SAMPLE_W-1:0] smp,
                                      input logic signed [SAMPLE_W-1:0] acc,
                                      input logic last);
    mix_t   r;
    longint smp_l, acc_l, old_l, new_l, frame_l, slew_l;
    longint gain, prod, sum;
    int     chans;
    logic   ramp;
    smp_l   = smp;
    acc_l   = acc;
    old_l   = old_gain_q;
    new_l   = new_gain_q;
    frame_l = ramp_frame_q;
    slew_l  = slew_q;
    ramp = (slew_q != '0) && (ramp_frame_q < slew_q);
    // signed divide truncates toward zero, as the ramp needs
    if (ramp)
      gain = old_l + ((new_l - old_l) * frame_l) / slew_l;
    else
      gain = new_l;
    prod = smp_l * gain;
    sum  = acc_l + ((prod + ROUND_BIAS) >>> FRAC_DROP);
    if (sum > SAT_HI) sum = SAT_HI;
    if (sum < SAT_LO) sum = SAT_LO;

    if (chans_q == '0)
      chans = 1;
    else if (chans_q > MAX_CHANNELS)
      chans = MAX_CHANNELS;
    else
      chans = chans_q;
    // an index left beyond a lowered count also closes the frame
    if (chan_pos + 1 >= chans) begin
      chan_pos = 0;
      if (ramp)
        ramp_frame_q = ramp_frame_q + 1'b1;
    end else begin
      chan_pos++;
    end

    r.accum   = sum[SAMPLE_W-1:0];
    r.ramping = ramp;
    r.last    = last;
    return r;
  endfunction

  always @(posedge clk) begin
    mix_t oldest;
    if (!rst_n) begin
      old_gain_q   = OLD_GAIN_RST;
      new_gain_q   = NEW_GAIN_RST;
      slew_q       = SLEW_RST;
      chans_q      = CHCNT_RST;
      ramp_frame_q = '0;
      chan_pos     = 0;
      pending_mixes.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OLD_GAIN: begin
            old_gain_q   = cfg_data[GAIN_W-1:0];
            ramp_frame_q = '0;
          end
          REG_NEW_GAIN: begin
            new_gain_q   = cfg_data[GAIN_W-1:0];
            ramp_frame_q = '0;
          end
          REG_SLEW_FRAMES: slew_q  = cfg_data[SLEW_W-1:0];
          REG_CHAN_COUNT:  chans_q = cfg_data[CHCNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (pending_mixes.size() == 0) begin
          report_mismatch($sformatf("result with none outstanding, accum_out=%0d",
                                    out_accum_out));
        end else begin
          oldest = pending_mixes[0];
          pending_mixes.delete(0);
          if (out_accum_out !== oldest.accum)
            report_mismatch($sformatf("accum_out %0d, predicted %0d",
                                      out_accum_out, oldest.accum));
          if (out_ramping !== oldest.ramping)
            report_mismatch($sformatf("ramping %b, predicted %b",
                                      out_ramping, oldest.ramping));
          if (out_out_last !== oldest.last)
            report_mismatch($sformatf("out_last %b, predicted %b",
                                      out_out_last, oldest.last));
          n_checked++;
          if (oldest.ramping)
            n_ramp++;
        end
      end

      if (in_valid && !in_stall)
        pending_mixes.insert(pending_mixes.size(),
                             mix_sample(in_sample_in, in_accum_in, in_block_last));
    end

    fail_count    <= n_fail;
    mixes_pending <= pending_mixes.size();
    mixes_checked <= n_checked;
    ramp_mixes    <= n_ramp;
  end

endmodule

// ===== bench/tb_send_gain_slew_mixer_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the send gain slew mixer: stimulus, register writes and verdict.
module tb_send_gain_slew_mixer_top;
  import sgsm_pkg::*;

  localparam logic [CFG_IDX_W-1:0]       REG_SPARE_LO = 3'd4;  // unused indexes from here up
  localparam logic [CFG_IDX_W-1:0]       REG_SPARE_HI = 3'd7;
  localparam logic signed [SAMPLE_W-1:0] S_MAX    = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN    = 24'sh800000;
  localparam logic [GAIN_W-1:0]          GAIN_MAX = 16'hFFFF;
  localparam logic [GAIN_W-1:0]          UNITY    = 16'd4096;
  localparam logic [SLEW_W-1:0]          SLEW_MAX = 12'hFFF;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 66;
  localparam int SETTLE_CYCLES = 80;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic signed [SAMPLE_W-1:0] in_accum_in = '0;
  logic                       in_block_last = 1'b0;
  logic                       out_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = REG_OLD_GAIN;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  logic                       in_stall;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_accum_out;
  logic                       out_ramping;
  logic                       out_out_last;
  logic                       cfg_ready;

  int fail_count, mixes_pending, mixes_checked, ramp_mixes;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int reg_writes = 0;

  always #5 clk = ~clk;

  send_gain_slew_mixer_top uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_accum_in   (in_accum_in),
    .in_block_last (in_block_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_accum_out (out_accum_out),
    .out_ramping   (out_ramping),
    .out_out_last  (out_out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  sgsm_mix_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample_in  (in_sample_in),
    .in_accum_in   (in_accum_in),
    .in_block_last (in_block_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_accum_out (out_accum_out),
    .out_ramping   (out_ramping),
    .out_out_last  (out_out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .mixes_pending (mixes_pending),
    .mixes_checked (mixes_checked),
    .ramp_mixes    (ramp_mixes)
  );

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // Leaves valid high when the next item follows right away.
  task automatic send_mix(input logic signed [SAMPLE_W-1:0] smp,
                          input logic signed [SAMPLE_W-1:0] acc,
                          input logic last);
    int gap;
    in_valid      <= 1'b1;
    in_sample_in  <= smp;
    in_accum_in   <= acc;
    in_block_last <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 64);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mixes_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 57; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 57; end
      default: begin send_idle_pct = 30; stall_pct = 30; end
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = S_MAX;
      1: v = S_MIN;
      2: begin
        v = SAMPLE_W'($urandom_range(63));
        v = v - 32;  // near zero, where rounding shows
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return GAIN_MAX;
      2: return UNITY;
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // Upper data bits are random; the block keeps only the register width.
  function automatic logic [CFG_DATA_W-1:0] pick_slew();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(7))
      0: d[SLEW_W-1:0] = '0;
      1: d[SLEW_W-1:0] = SLEW_MAX;
      default: d[SLEW_W-1:0] = SLEW_W'($urandom_range(1, 8));
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_chans();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(7))
      0: d[CHCNT_W-1:0] = '0;
      1: d[CHCNT_W-1:0] = CHCNT_W'($urandom_range(9, 15));
      2: d[CHCNT_W-1:0] = 4'd8;
      3: d[CHCNT_W-1:0] = 4'd1;
      default: d[CHCNT_W-1:0] = CHCNT_W'($urandom_range(1, 8));
    endcase
    return d;
  endfunction

  initial begin : stimulus
    int seg, k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset levels: unity gain, no ramp, two channels
    send_mix('0, '0, 1'b0);
    send_mix(S_MAX, '0, 1'b1);
    send_mix(S_MIN, '0, 1'b0);
    send_mix(S_MAX, S_MAX, 1'b0);
    send_mix(S_MIN, S_MIN, 1'b1);
    send_mix(24'sd1, -24'sd1, 1'b0);

    // rising ramp over three single-channel frames, full scale gain at the end
    wait_drained();
    write_reg(REG_OLD_GAIN, '0);
    write_reg(REG_NEW_GAIN, GAIN_MAX);
    write_reg(REG_SLEW_FRAMES, 16'd3);
    write_reg(REG_CHAN_COUNT, 16'd1);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    send_mix(S_MAX, S_MIN, 1'b0);
    send_mix(S_MIN, S_MAX, 1'b0);
    send_mix(24'sd4095, 24'sd7, 1'b1);
    send_mix(S_MAX, S_MAX, 1'b0);
    send_mix(S_MIN, S_MIN, 1'b1);

    // falling ramp, three channels; stops mid-frame
    wait_drained();
    write_reg(REG_OLD_GAIN, GAIN_MAX);
    write_reg(REG_NEW_GAIN, '0);
    write_reg(REG_SLEW_FRAMES, 16'd7);
    write_reg(REG_CHAN_COUNT, 16'd3);
    send_mix(S_MAX, '0, 1'b0);
    send_mix(S_MIN, '0, 1'b1);
    send_mix(24'sd12345, -24'sd5, 1'b0);
    send_mix(-24'sd777, 24'sd3, 1'b0);

    // count lowered below the channel position
    wait_drained();
    write_reg(REG_CHAN_COUNT, 16'd1);
    send_mix(S_MAX, 24'sd100, 1'b0);
    send_mix(-24'sd3, '0, 1'b1);

    // ramp shortened below the frames already done
    wait_drained();
    write_reg(REG_SLEW_FRAMES, 16'd1);
    send_mix(S_MAX, -24'sd9, 1'b0);
    send_mix(S_MIN, 24'sd9, 1'b0);

    // zero and oversized counts, with junk in the upper data bits
    wait_drained();
    write_reg(REG_SLEW_FRAMES, 16'hF000);
    write_reg(REG_CHAN_COUNT, 16'hFFF0);
    send_mix(S_MAX, S_MIN, 1'b1);
    send_mix(24'sd2048, '0, 1'b0);
    wait_drained();
    write_reg(REG_CHAN_COUNT, 16'hFFFF);
    send_mix(S_MIN, S_MAX, 1'b0);
    send_mix(24'sd1, '0, 1'b1);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      set_idling(seg);
      write_reg(REG_OLD_GAIN, pick_gain());
      write_reg(REG_NEW_GAIN, pick_gain());
      write_reg(REG_SLEW_FRAMES, pick_slew());
      write_reg(REG_CHAN_COUNT, pick_chans());
      if ($urandom_range(1))
        write_reg(REG_SPARE_LO + CFG_IDX_W'($urandom_range(3)), CFG_DATA_W'($urandom));
      for (k = 0; k < SEG_ITEMS; k++) begin
        // halfway: retune length or width without restarting the ramp
        if (k == SEG_ITEMS / 2) begin
          wait_drained();
          if ($urandom_range(1))
            write_reg(REG_SLEW_FRAMES, pick_slew());
          else
            write_reg(REG_CHAN_COUNT, pick_chans());
        end
        send_mix(pick_sample(), pick_sample(), ($urandom_range(7) == 0));
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d items and %0d register writes over four idling patterns,",
             items_sent, reg_writes);
    $display("with %0d results compared, %0d of them taken on a gain ramp.",
             mixes_checked, ramp_mixes);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("Timed out with %0d results outstanding.", mixes_pending);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sgsm_pkg.sv
rtl/core/send_gain_slew_mixer_top.sv
bench/sgsm_mix_checker.sv
bench/tb_send_gain_slew_mixer_top.sv
